// ===== rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== rtl/rog_pkg.sv =====
package rog_pkg;
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0] atom_mass;
    logic last_atom;
  } in_item_t;

  typedef struct packed {
    logic [31:0] gyration_radius;
    logic [31:0] max_distance;
    logic too_light;
  } out_item_t;

  // one queued atom after classification
  typedef struct packed {
    logic store;
    logic last;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [15:0] w;
  } job_t;

  localparam logic [15:0] ONE_Q8 = 16'd256;
  localparam logic [0:0] REG_USE_MASS = 1'b0;
  localparam logic [0:0] REG_MIN_TOTAL = 1'b1;
endpackage

// ===== rtl/rog_ram.sv =====
module rog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rog_front.sv =====
// classifies items: picks weight, decides whether the atom is stored
`include "assert_macros.svh"
module rog_front #(
  parameter int MAX_ATOMS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  rog_pkg::in_item_t in_data,
  input  logic use_mass,
  output logic q_valid,
  input  logic q_pop,
  output rog_pkg::job_t q_job
);
  localparam int CW = $clog2(MAX_ATOMS + 1);
  logic [CW-1:0] cnt_r;
  rog_pkg::job_t q_r [2];
  logic [1:0] fill_r;
  logic rd_r, wr_r;
  logic acc;
  rog_pkg::job_t j;

  assign in_stall = (fill_r == 2'd2);
  assign acc = in_valid && !in_stall;
  assign q_valid = (fill_r != 2'd0);
  assign q_job = q_r[rd_r];

  always_comb begin
    j.store = (cnt_r < CW'(MAX_ATOMS));
    j.last = in_data.last_atom;
    j.x = in_data.pos_x;
    j.y = in_data.pos_y;
    j.z = in_data.pos_z;
    j.w = use_mass ? in_data.atom_mass : rog_pkg::ONE_Q8;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fill_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      if (acc) begin
        q_r[wr_r] <= j;
        wr_r <= !wr_r;
        if (in_data.last_atom) cnt_r <= '0;
        else if (j.store) cnt_r <= cnt_r + 1'b1;
      end
      if (q_pop && q_valid) rd_r <= !rd_r;
      fill_r <= fill_r + {1'b0, acc} - {1'b0, q_pop && q_valid};
    end
  end

  `ASSERT_NEVER(a_q_over, clk, rst_n, fill_r > 2'd2, "queue overfull")
  `ASSERT_CLK(a_cnt, clk, rst_n, cnt_r <= CW'(MAX_ATOMS), "count past depth")
  `ASSERT_CLK(a_pop, clk, rst_n, q_pop |-> q_valid, "pop of empty queue")
endmodule

// ===== rtl/rog_back.sv =====
// executes queued atoms: load, then second pass, divide and root
`include "assert_macros.svh"
module rog_back #(
  parameter int MAX_ATOMS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  rog_pkg::job_t q_job,
  input  logic [15:0] min_total,
  output logic out_valid,
  input  logic out_stall,
  output rog_pkg::out_item_t out_data
);
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CW = $clog2(MAX_ATOMS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CDIV, S_PREP, S_RD, S_SQ, S_SUM, S_WMUL, S_ACC,
    S_DDIV, S_ROOT, S_OUT
  } st_t;

  st_t st_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic signed [63:0] sx_r, sy_r, sz_r;
  logic [31:0] tot_r;
  logic signed [63:0] cx_r, cy_r, cz_r;
  logic [63:0] sum_r, max_r, wd_r;
  logic [15:0] maxw_r;
  logic [63:0] dx2_r, dy2_r, dz2_r, d2_r;
  logic [63:0] num_r, den_r, rem_r, quo_r, root_r;
  logic [6:0] step_r;
  logic [31:0] gr_r;
  logic tl_r;
  logic ovalid_r;
  rog_pkg::out_item_t odata_r;
  logic [15:0] curw_r;
  logic sgn_r;
  logic [1:0] axis_r;

  logic [31:0] rx, ry, rz;
  logic [15:0] rw;
  logic we;
  logic [AW-1:0] waddr, raddr;

  assign we = (st_r == S_IDLE) && q_valid && q_job.store;
  assign waddr = cnt_r[AW-1:0];
  assign raddr = idx_r[AW-1:0];

  rog_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_rx (.clk, .we, .waddr, .wdata(q_job.x),
    .raddr, .rdata(rx));
  rog_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_ry (.clk, .we, .waddr, .wdata(q_job.y),
    .raddr, .rdata(ry));
  rog_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_rz (.clk, .we, .waddr, .wdata(q_job.z),
    .raddr, .rdata(rz));
  rog_ram #(.WIDTH(16), .DEPTH(MAX_ATOMS)) u_rw (.clk, .we, .waddr, .wdata(q_job.w),
    .raddr, .rdata(rw));

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = ovalid_r;
  assign out_data = odata_r;

  // helpers
  function automatic logic [63:0] abs_d(logic [31:0] c, logic signed [63:0] ctr);
    logic signed [64:0] d;
    d = {{33{c[31]}}, c} - {ctr[63], ctr};
    return d[64] ? 64'(-d) : d[63:0];
  endfunction

  function automatic logic [63:0] sadd(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  logic [63:0] ddx, ddy, ddz;
  logic [79:0] wprod;
  logic [64:0] trial;

  always_comb begin
    ddx = abs_d(rx, cx_r);
    ddy = abs_d(ry, cy_r);
    ddz = abs_d(rz, cz_r);
    wprod = d2_r * {64'd0, curw_r};
    trial = {rem_r[62:0], num_r[63]} - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      tot_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && !out_stall && st_r != S_OUT) ovalid_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_job.store) begin
              sx_r <= sx_r + 64'(q_job.x * $signed({1'b0, q_job.w}));
              sy_r <= sy_r + 64'(q_job.y * $signed({1'b0, q_job.w}));
              sz_r <= sz_r + 64'(q_job.z * $signed({1'b0, q_job.w}));
              tot_r <= (({1'b0, tot_r} + 33'(q_job.w)) > 33'hFFFFFFFF) ? '1
                     : tot_r + 32'(q_job.w);
              cnt_r <= cnt_r + 1'b1;
            end
            if (q_job.last) st_r <= S_CDIV;
            axis_r <= 2'd0;
            step_r <= 7'd0;
          end
        end
        S_CDIV: begin
          // center divide: signed sum over total, one quotient bit a cycle; too small a total skips to output
          if (tot_r == 32'd0 || tot_r < {16'd0, min_total}) begin
            gr_r <= '0;
            num_r <= '0;
            tl_r <= 1'b1;
            st_r <= S_OUT;
          end else if (step_r == 7'd0) begin
            case (axis_r)
              2'd0: begin sgn_r <= sx_r[63]; num_r <= sx_r[63] ? -sx_r : sx_r; end
              2'd1: begin sgn_r <= sy_r[63]; num_r <= sy_r[63] ? -sy_r : sy_r; end
              default: begin sgn_r <= sz_r[63]; num_r <= sz_r[63] ? -sz_r : sz_r; end
            endcase
            den_r <= {32'd0, tot_r};
            rem_r <= '0;
            quo_r <= '0;
            step_r <= 7'd1;
          end else if (step_r <= 7'd64) begin
            if (!trial[64]) begin
              rem_r <= trial[63:0];
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= {rem_r[62:0], num_r[63]};
              quo_r <= {quo_r[62:0], 1'b0};
            end
            num_r <= {num_r[62:0], 1'b0};
            step_r <= step_r + 1'b1;
          end else begin
            case (axis_r)
              2'd0: cx_r <= sgn_r ? -quo_r : quo_r;
              2'd1: cy_r <= sgn_r ? -quo_r : quo_r;
              default: cz_r <= sgn_r ? -quo_r : quo_r;
            endcase
            step_r <= 7'd0;
            if (axis_r == 2'd2) begin
              st_r <= S_PREP;
            end else begin
              axis_r <= axis_r + 1'b1;
            end
          end
        end
        S_PREP: begin
          idx_r <= '0;
          sum_r <= '0;
          max_r <= '0;
          maxw_r <= rog_pkg::ONE_Q8;
          curw_r <= rog_pkg::ONE_Q8;
          tl_r <= 1'b0;
          st_r <= (cnt_r == '0) ? S_DDIV : S_RD;
        end
        S_RD: st_r <= S_SQ;  // ram read latency
        S_SQ: begin
          // distances fit 32 bits, so each square is a 32 by 32 product
          dx2_r <= ddx[31:0] * ddx[31:0];
          dy2_r <= ddy[31:0] * ddy[31:0];
          dz2_r <= ddz[31:0] * ddz[31:0];
          curw_r <= rw;
          st_r <= S_SUM;
        end
        S_SUM: begin
          d2_r <= sadd(sadd(dx2_r, dy2_r), dz2_r);
          st_r <= S_WMUL;
        end
        S_WMUL: begin
          wd_r <= (wprod[79:64] != 16'd0) ? '1 : wprod[63:0];
          st_r <= S_ACC;
        end
        S_ACC: begin
          if (wd_r > max_r) begin
            max_r <= wd_r;
            maxw_r <= curw_r;
          end
          sum_r <= sadd(sum_r, wd_r);
          if (idx_r + 1'b1 == cnt_r) begin
            st_r <= S_DDIV;
            axis_r <= 2'd0;
            step_r <= 7'd0;
          end else begin
            idx_r <= idx_r + 1'b1;
            st_r <= S_RD;
          end
        end
        S_DDIV: begin
          // unsigned divide then root, for the sum and then the maximum
          if (step_r == 7'd0) begin
            num_r <= (axis_r == 2'd0) ? sum_r : max_r;
            den_r <= (axis_r == 2'd0) ? {32'd0, tot_r} : {48'd0, maxw_r};
            rem_r <= '0;
            quo_r <= '0;
            step_r <= 7'd1;
          end else if (step_r <= 7'd64) begin
            if (!trial[64]) begin
              rem_r <= trial[63:0];
              quo_r <= {quo_r[62:0], 1'b1};
            end else begin
              rem_r <= {rem_r[62:0], num_r[63]};
              quo_r <= {quo_r[62:0], 1'b0};
            end
            num_r <= {num_r[62:0], 1'b0};
            step_r <= step_r + 1'b1;
          end else begin
            num_r <= quo_r;   // radicand
            rem_r <= '0;      // remainder of root
            root_r <= '0;
            step_r <= 7'd0;
            st_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          // two bits of radicand per cycle
          if (step_r < 7'd32) begin
            if ({rem_r[61:0], num_r[63:62]} >= {root_r[61:0], 2'b01}) begin
              rem_r <= {rem_r[61:0], num_r[63:62]} - {root_r[61:0], 2'b01};
              root_r <= {root_r[62:0], 1'b1};
            end else begin
              rem_r <= {rem_r[61:0], num_r[63:62]};
              root_r <= {root_r[62:0], 1'b0};
            end
            num_r <= {num_r[61:0], 2'b00};
            step_r <= step_r + 1'b1;
          end else if (axis_r == 2'd0) begin
            gr_r <= root_r[31:0];
            axis_r <= 2'd1;
            step_r <= 7'd0;
            st_r <= S_DDIV;
          end else begin
            num_r <= root_r;
            st_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || !out_stall) begin
            ovalid_r <= 1'b1;
            odata_r.gyration_radius <= gr_r;
            odata_r.max_distance <= num_r[31:0];
            odata_r.too_light <= tl_r;
            cnt_r <= '0;
            sx_r <= '0; sy_r <= '0; sz_r <= '0;
            tot_r <= '0;
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_hold, clk, rst_n, (out_valid && out_stall) |=> out_valid, "result dropped")
  `ASSERT_CLK(a_idx, clk, rst_n, (st_r == S_ACC) |-> (idx_r < cnt_r), "pass past count")
  `ASSERT_CLK(a_pop, clk, rst_n, q_pop |-> (st_r == S_IDLE), "pop while busy")
endmodule

// ===== rtl/radius_of_gyration_top.sv =====
// an atom is registered in the front queue and taken by the back end while it is idle, one atom per cycle
// a last atom starts three center divides, a second pass over the stored atoms, two divides
// and two roots; a too-light selection skips straight to the output
// loads run one per cycle while the back end is idle; the bit-serial divider and root set the tail
// rst_n is synchronous active low; clears the selection and sets use_mass 0, threshold 1
// atom stores have no reset and need no clearing pass
`include "assert_macros.svh"
module radius_of_gyration_top #(
  parameter int MAX_ATOMS = 4096
) (
  input  logic clk,
  input  logic rst_n,
  // input channel
  input  logic in_valid,
  output logic in_stall,
  input  rog_pkg::in_item_t in_data,
  // result channel
  output logic out_valid,
  input  logic out_stall,
  output rog_pkg::out_item_t out_data,
  // register port
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic use_mass_r;
  logic [15:0] min_total_r;
  logic q_valid, q_pop;
  rog_pkg::job_t q_job;

  assign pready = 1'b1;
  // register read mux
  assign prdata = (paddr[2] == rog_pkg::REG_MIN_TOTAL) ? {16'd0, min_total_r}
                : {31'd0, use_mass_r};

  // register write on the access cycle of a transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_mass_r <= 1'b0;
      min_total_r <= 16'd1;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == rog_pkg::REG_USE_MASS) use_mass_r <= pwdata[0];
      else min_total_r <= pwdata[15:0];
    end
  end

  // front: weight selection and store-full check, two-entry queue
  rog_front #(.MAX_ATOMS(MAX_ATOMS)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .use_mass(use_mass_r), .q_valid, .q_pop, .q_job
  );

  // back: accumulation, second pass, divides and roots
  rog_back #(.MAX_ATOMS(MAX_ATOMS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_job,
    .min_total(min_total_r), .out_valid, .out_stall, .out_data
  );

  `ASSERT_CLK(a_ready, clk, rst_n, pready, "pready low")
  `ASSERT_CLK(a_out_stable, clk, rst_n, (out_valid && out_stall) |=> $stable(out_data), "result changed while stalled")
  `ASSERT_NEVER(a_prdata, clk, rst_n, prdata[31:16] != 16'd0, "read data upper bits set")
endmodule
